[design/acrr_pkg.sv]
package acrr_pkg;

  localparam int TABLE_ENTRIES = 16;
  localparam int IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

  localparam logic [15:0] MIN_ARP_LEN = 16'd28;
  localparam logic [15:0] HTYPE_ETH   = 16'h0001;
  localparam logic [15:0] PTYPE_IPV4  = 16'h0800;
  localparam logic [7:0]  HLEN_ETH    = 8'd6;
  localparam logic [7:0]  PLEN_IPV4   = 8'd4;
  localparam logic [15:0] OP_REQUEST  = 16'd1;

  typedef logic [IDX_W-1:0] idx_t;

  typedef enum logic [0:0] {
    CMD_PACKET = 1'b0,
    CMD_LOOKUP = 1'b1
  } cmd_t;

  typedef enum logic [0:0] {
    CFG_LOCAL_IP  = 1'b0,
    CFG_LOCAL_MAC = 1'b1
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_READ,
    ST_CMP,
    ST_WRITE
  } ctrl_state_t;

  typedef struct packed {
    logic [31:0] ip;
    logic [47:0] mac;
  } entry_t;

  typedef struct packed {
    logic   en;
    idx_t   addr;
    entry_t data;
  } tbl_wr_t;

endpackage

[design/arp_cache_with_request_reply_top.sv]
// ARP cache with request/reply detection. An item is taken when start is high
// and busy is low; its single result appears on the out_ ports for one cycle
// with out_valid and cannot be held off. A lookup, or a packet that passes the
// header and target checks with a nonzero sender IP, scans the 16-entry table
// one entry at a time (memory read, then compare); a lookup stops at a hit or
// the last entry, and a packet ends with a write of its entry. A rejected
// packet, one not addressed to us, or one with a zero sender IP answers in the
// cycle after it is taken. busy drops in the cycle the result is out.
// Configuration writes take effect at the next clock edge.
module arp_cache_with_request_reply_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        start,
  output logic        busy,
  input  logic        in_command,
  input  logic [15:0] in_packet_length,
  input  logic [15:0] in_hw_type,
  input  logic [15:0] in_proto_type,
  input  logic [7:0]  in_hw_addr_len,
  input  logic [7:0]  in_proto_addr_len,
  input  logic [15:0] in_arp_opcode,
  input  logic [31:0] in_src_ip,
  input  logic [47:0] in_src_mac,
  input  logic [31:0] in_tgt_ip,
  input  logic [31:0] in_lookup_ip,
  output logic        out_valid,
  output logic        out_lookup_hit,
  output logic [47:0] out_lookup_mac,
  output logic        out_send_reply,
  output logic [31:0] out_reply_tgt_ip,
  output logic [47:0] out_reply_tgt_mac,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [47:0] cfg_wdata
);

  logic [31:0] local_ip_r, local_ip_nxt;
  // local MAC register, written through cfg; no output carries it
  logic [47:0] local_mac_r, local_mac_nxt;

  acrr_pkg::idx_t    rd_addr;
  acrr_pkg::entry_t  rd_data;
  acrr_pkg::tbl_wr_t wr;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      local_ip_r  <= '0;
      local_mac_r <= '0;
    end else begin
      local_ip_r  <= local_ip_nxt;
      local_mac_r <= local_mac_nxt;
    end
  end

  always_comb begin
    local_ip_nxt  = local_ip_r;
    local_mac_nxt = local_mac_r;
    if (cfg_we) begin
      unique case (acrr_pkg::cfg_reg_t'(cfg_index))
        acrr_pkg::CFG_LOCAL_IP:  local_ip_nxt  = cfg_wdata[31:0];
        acrr_pkg::CFG_LOCAL_MAC: local_mac_nxt = cfg_wdata;
        default: ;
      endcase
    end
  end

  acrr_table_ram u_ram (
    .clk     (clk),
    .wr      (wr),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  acrr_ctrl u_ctrl (
    .clk               (clk),
    .rst_n             (rst_n),
    .start             (start),
    .busy              (busy),
    .in_command        (in_command),
    .in_packet_length  (in_packet_length),
    .in_hw_type        (in_hw_type),
    .in_proto_type     (in_proto_type),
    .in_hw_addr_len    (in_hw_addr_len),
    .in_proto_addr_len (in_proto_addr_len),
    .in_arp_opcode     (in_arp_opcode),
    .in_src_ip         (in_src_ip),
    .in_src_mac        (in_src_mac),
    .in_tgt_ip         (in_tgt_ip),
    .in_lookup_ip      (in_lookup_ip),
    .local_ip          (local_ip_r),
    .rd_addr           (rd_addr),
    .rd_data           (rd_data),
    .wr                (wr),
    .out_valid         (out_valid),
    .out_lookup_hit    (out_lookup_hit),
    .out_lookup_mac    (out_lookup_mac),
    .out_send_reply    (out_send_reply),
    .out_reply_tgt_ip  (out_reply_tgt_ip),
    .out_reply_tgt_mac (out_reply_tgt_mac)
  );

endmodule

[design/acrr_table_ram.sv]
module acrr_table_ram (
  input  logic             clk,
  input  acrr_pkg::tbl_wr_t wr,
  input  acrr_pkg::idx_t   rd_addr,
  output acrr_pkg::entry_t rd_data
);

  acrr_pkg::entry_t mem [acrr_pkg::TABLE_ENTRIES];
  acrr_pkg::entry_t rd_data_r;

  always_ff @(posedge clk) begin
    if (wr.en) begin
      mem[wr.addr] <= wr.data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data_r <= mem[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

[design/acrr_ctrl.sv]
module acrr_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  output logic              busy,
  input  logic              in_command,
  input  logic [15:0]       in_packet_length,
  input  logic [15:0]       in_hw_type,
  input  logic [15:0]       in_proto_type,
  input  logic [7:0]        in_hw_addr_len,
  input  logic [7:0]        in_proto_addr_len,
  input  logic [15:0]       in_arp_opcode,
  input  logic [31:0]       in_src_ip,
  input  logic [47:0]       in_src_mac,
  input  logic [31:0]       in_tgt_ip,
  input  logic [31:0]       in_lookup_ip,
  input  logic [31:0]       local_ip,
  output acrr_pkg::idx_t    rd_addr,
  input  acrr_pkg::entry_t  rd_data,
  output acrr_pkg::tbl_wr_t wr,
  output logic              out_valid,
  output logic              out_lookup_hit,
  output logic [47:0]       out_lookup_mac,
  output logic              out_send_reply,
  output logic [31:0]       out_reply_tgt_ip,
  output logic [47:0]       out_reply_tgt_mac
);

  localparam acrr_pkg::idx_t IDX_LAST = acrr_pkg::idx_t'(acrr_pkg::TABLE_ENTRIES - 1);

  acrr_pkg::ctrl_state_t state_r, state_nxt;
  acrr_pkg::idx_t idx_r, idx_nxt;
  acrr_pkg::idx_t free_idx_r, free_idx_nxt;
  acrr_pkg::idx_t victim_r, victim_nxt;
  acrr_pkg::idx_t wr_idx_r, wr_idx_nxt;
  logic free_found_r, free_found_nxt;
  logic is_lookup_r, is_lookup_nxt;
  logic is_req_r, is_req_nxt;
  logic [31:0] key_ip_r, key_ip_nxt;
  logic [47:0] mac_r, mac_nxt;
  logic [acrr_pkg::TABLE_ENTRIES-1:0] valid_r, valid_nxt;

  logic        out_valid_r, out_valid_nxt;
  logic        out_hit_r, out_hit_nxt;
  logic [47:0] out_lmac_r, out_lmac_nxt;
  logic        out_reply_r, out_reply_nxt;
  logic [31:0] out_rip_r, out_rip_nxt;
  logic [47:0] out_rmac_r, out_rmac_nxt;

  logic hdr_ok;
  logic for_us;
  logic is_req_in;
  logic match;
  logic idx_last;
  logic cur_free;

  assign hdr_ok = (in_packet_length >= acrr_pkg::MIN_ARP_LEN) &&
                  (in_hw_type == acrr_pkg::HTYPE_ETH) &&
                  (in_proto_type == acrr_pkg::PTYPE_IPV4) &&
                  (in_hw_addr_len == acrr_pkg::HLEN_ETH) &&
                  (in_proto_addr_len == acrr_pkg::PLEN_IPV4);
  assign for_us    = (in_tgt_ip == local_ip);
  assign is_req_in = (in_arp_opcode == acrr_pkg::OP_REQUEST);

  assign match    = valid_r[idx_r] && (rd_data.ip == key_ip_r);
  assign idx_last = (idx_r == IDX_LAST);
  assign cur_free = !valid_r[idx_r];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= acrr_pkg::ST_IDLE;
      valid_r     <= '0;
      victim_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      valid_r     <= valid_nxt;
      victim_r    <= victim_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    idx_r        <= idx_nxt;
    free_idx_r   <= free_idx_nxt;
    free_found_r <= free_found_nxt;
    wr_idx_r     <= wr_idx_nxt;
    is_lookup_r  <= is_lookup_nxt;
    is_req_r     <= is_req_nxt;
    key_ip_r     <= key_ip_nxt;
    mac_r        <= mac_nxt;
    out_hit_r    <= out_hit_nxt;
    out_lmac_r   <= out_lmac_nxt;
    out_reply_r  <= out_reply_nxt;
    out_rip_r    <= out_rip_nxt;
    out_rmac_r   <= out_rmac_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    idx_nxt        = idx_r;
    free_idx_nxt   = free_idx_r;
    free_found_nxt = free_found_r;
    victim_nxt     = victim_r;
    wr_idx_nxt     = wr_idx_r;
    is_lookup_nxt  = is_lookup_r;
    is_req_nxt     = is_req_r;
    key_ip_nxt     = key_ip_r;
    mac_nxt        = mac_r;
    valid_nxt      = valid_r;
    out_valid_nxt  = 1'b0;
    out_hit_nxt    = out_hit_r;
    out_lmac_nxt   = out_lmac_r;
    out_reply_nxt  = out_reply_r;
    out_rip_nxt    = out_rip_r;
    out_rmac_nxt   = out_rmac_r;
    wr.en          = 1'b0;
    wr.addr        = wr_idx_r;
    wr.data.ip     = key_ip_r;
    wr.data.mac    = mac_r;

    unique case (state_r)
      acrr_pkg::ST_IDLE: begin
        if (start) begin
          idx_nxt        = '0;
          free_found_nxt = 1'b0;
          is_req_nxt     = is_req_in;
          mac_nxt        = in_src_mac;
          if (in_command == acrr_pkg::CMD_LOOKUP) begin
            is_lookup_nxt = 1'b1;
            key_ip_nxt    = in_lookup_ip;
            state_nxt     = acrr_pkg::ST_READ;
          end else if (hdr_ok && for_us && (in_src_ip != '0)) begin
            is_lookup_nxt = 1'b0;
            key_ip_nxt    = in_src_ip;
            state_nxt     = acrr_pkg::ST_READ;
          end else begin
            // rejected, not for us, or zero sender IP: answer right away
            out_valid_nxt = 1'b1;
            out_hit_nxt   = 1'b0;
            out_lmac_nxt  = '0;
            out_reply_nxt = hdr_ok && for_us && is_req_in;
            out_rip_nxt   = out_reply_nxt ? in_src_ip : '0;
            out_rmac_nxt  = out_reply_nxt ? in_src_mac : '0;
          end
        end
      end
      acrr_pkg::ST_READ: begin
        state_nxt = acrr_pkg::ST_CMP;
      end
      acrr_pkg::ST_CMP: begin
        if (is_lookup_r) begin
          if (match || idx_last) begin
            out_valid_nxt = 1'b1;
            out_hit_nxt   = match;
            out_lmac_nxt  = match ? rd_data.mac : '0;
            out_reply_nxt = 1'b0;
            out_rip_nxt   = '0;
            out_rmac_nxt  = '0;
            state_nxt     = acrr_pkg::ST_IDLE;
          end else begin
            idx_nxt   = idx_r + 1'b1;
            state_nxt = acrr_pkg::ST_READ;
          end
        end else begin
          if (match) begin
            wr_idx_nxt = idx_r;
            state_nxt  = acrr_pkg::ST_WRITE;
          end else begin
            if (cur_free && !free_found_r) begin
              free_found_nxt = 1'b1;
              free_idx_nxt   = idx_r;
            end
            if (idx_last) begin
              if (free_found_nxt) begin
                wr_idx_nxt = free_idx_nxt;
              end else begin
                wr_idx_nxt = victim_r;
                victim_nxt = (victim_r == IDX_LAST) ? '0 : victim_r + 1'b1;
              end
              state_nxt = acrr_pkg::ST_WRITE;
            end else begin
              idx_nxt   = idx_r + 1'b1;
              state_nxt = acrr_pkg::ST_READ;
            end
          end
        end
      end
      acrr_pkg::ST_WRITE: begin
        wr.en               = 1'b1;
        valid_nxt[wr_idx_r] = 1'b1;
        out_valid_nxt       = 1'b1;
        out_hit_nxt         = 1'b0;
        out_lmac_nxt        = '0;
        out_reply_nxt       = is_req_r;
        out_rip_nxt         = is_req_r ? key_ip_r : '0;
        out_rmac_nxt        = is_req_r ? mac_r : '0;
        state_nxt           = acrr_pkg::ST_IDLE;
      end
      default: begin
        state_nxt = acrr_pkg::ST_IDLE;
      end
    endcase
  end

  assign busy              = (state_r != acrr_pkg::ST_IDLE);
  assign rd_addr           = idx_r;
  assign out_valid         = out_valid_r;
  assign out_lookup_hit    = out_hit_r;
  assign out_lookup_mac    = out_lmac_r;
  assign out_send_reply    = out_reply_r;
  assign out_reply_tgt_ip  = out_rip_r;
  assign out_reply_tgt_mac = out_rmac_r;

  a_done_on_exit: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy) |-> out_valid)
    else $error("transaction left the scan without a result");

  a_victim_only_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    !$stable(victim_r) |-> (&$past(valid_r)))
    else $error("victim advanced while a free slot existed");

  a_written_valid: assert property (@(posedge clk) disable iff (!rst_n)
    wr.en |=> valid_r[$past(wr.addr)])
    else $error("written entry not marked valid");

  a_hit_xor_reply: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_lookup_hit) |-> !out_send_reply)
    else $error("lookup hit and reply in one result");

endmodule
